@@ design/hprld_pkg.sv @@
package hprld_pkg;

   localparam int URL_MAX_DEFAULT = 65;
   localparam int METHOD_COUNT    = 5;

   localparam logic [7:0] ASCII_SLASH = 8'h2F;
   localparam logic [7:0] ASCII_SPACE = 8'h20;

   // Method names, left aligned, padded with zeros.
   localparam logic [7:0] METHOD_TEXT [0:4][0:6] = '{
      '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00},
      '{"D", "E", "L", "E", "T", "E", 8'h00},
      '{"C", "O", "N", "N", "E", "C", "T"}
   };
   localparam logic [2:0] METHOD_LEN [0:4] = '{3'd3, 3'd3, 3'd4, 3'd6, 3'd7};

   // Entry 0 is HTTP/1.1 (version code 0), entry 1 is HTTP/1.0 (version code 1).
   localparam logic [7:0] VERSION_TEXT [0:1][0:7] = '{
      '{"H", "T", "T", "P", "/", "1", ".", "1"},
      '{"H", "T", "T", "P", "/", "1", ".", "0"}
   };
   localparam logic [2:0] VERSION_LAST = 3'd7;

   typedef struct packed {
      logic       valid;
      logic [2:0] method;
      logic       version;
   } launch_type;

   function automatic logic [7:0] method_char(input logic [2:0] idx, input logic [2:0] pos);
      logic [7:0] c;
      c = 8'h00;
      if (idx < 3'(METHOD_COUNT) && pos < 3'd7) begin
         c = METHOD_TEXT[idx][pos];
      end
      return c;
   endfunction

   function automatic logic [2:0] method_len(input logic [2:0] idx);
      logic [2:0] n;
      n = 3'd0;
      if (idx < 3'(METHOD_COUNT)) begin
         n = METHOD_LEN[idx];
      end
      return n;
   endfunction

   function automatic logic [7:0] version_char(input logic ver, input logic [2:0] k);
      return VERSION_TEXT[ver][k];
   endfunction

endpackage

@@ design/hprld_url_ram.sv @@
module hprld_url_ram #(
   parameter int DEPTH = hprld_pkg::URL_MAX_DEFAULT - 1,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/hprld_parser.sv @@
module hprld_parser #(
   parameter int URL_MAX = hprld_pkg::URL_MAX_DEFAULT,
   parameter int AW      = 6,
   parameter int LW      = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_accept,
   input  logic [7:0]             payload_byte,
   input  logic                   segment_end,
   input  logic                   detect_enable,
   output logic                   wr_en,
   output logic [AW-1:0]          wr_addr,
   output logic [7:0]             wr_data,
   output hprld_pkg::launch_type  launch,
   output logic [LW-1:0]          launch_len
);

   localparam logic [LW-1:0] URL_LIMIT = LW'(URL_MAX - 1);

   typedef enum logic [2:0] {
      PH_METHOD,
      PH_SKIP,
      PH_URL_FIRST,
      PH_URL,
      PH_VERSION,
      PH_IDLE
   } phase_type;

   phase_type     phase_ff, phase_in;
   logic [2:0]    pos_ff, pos_in;
   logic [4:0]    cand_ff, cand_in;
   logic [2:0]    method_ff, method_in;
   logic [LW-1:0] len_ff, len_in;
   logic [1:0]    vcand_ff, vcand_in;
   logic [2:0]    vidx_ff, vidx_in;

   logic [4:0]    cand_next;
   logic          hit;
   logic [2:0]    hit_idx;
   logic [1:0]    vcand_next;

   // Candidate pruning for the method name; each method is checked on its own.
   always_comb begin
      for (int i = 0; i < hprld_pkg::METHOD_COUNT; i++) begin
         cand_next[i] = cand_ff[i] && (pos_ff < hprld_pkg::method_len(3'(i)))
            && (hprld_pkg::method_char(3'(i), pos_ff) == payload_byte);
      end
      hit     = 1'b0;
      hit_idx = 3'd0;
      // Walk downward so the lowest matching method index wins.
      for (int i = hprld_pkg::METHOD_COUNT - 1; i >= 0; i--) begin
         if (cand_next[i] && ({1'b0, hprld_pkg::method_len(3'(i))} == {1'b0, pos_ff} + 4'd1)) begin
            hit     = 1'b1;
            hit_idx = 3'(i);
         end
      end
      for (int j = 0; j < 2; j++) begin
         vcand_next[j] = vcand_ff[j] && (hprld_pkg::version_char(j[0], vidx_ff) == payload_byte);
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      pos_in         = pos_ff;
      cand_in        = cand_ff;
      method_in      = method_ff;
      len_in         = len_ff;
      vcand_in       = vcand_ff;
      vidx_in        = vidx_ff;
      wr_en          = 1'b0;
      wr_addr        = len_ff[AW-1:0];
      wr_data        = payload_byte;
      launch.valid   = 1'b0;
      launch.method  = method_ff;
      launch.version = ~vcand_next[0];
      launch_len     = len_ff;

      if (in_accept) begin
         unique case (phase_ff)
            PH_METHOD: begin
               cand_in = cand_next;
               if (cand_next == 5'd0) begin
                  phase_in = PH_IDLE;
               end else if (hit) begin
                  method_in = hit_idx;
                  phase_in  = PH_SKIP;
               end
               if (pos_ff != 3'd7) begin
                  pos_in = pos_ff + 3'd1;
               end
            end
            PH_SKIP: begin
               phase_in = PH_URL_FIRST;
            end
            PH_URL_FIRST: begin
               if (payload_byte == hprld_pkg::ASCII_SLASH) begin
                  phase_in = PH_IDLE;
               end else begin
                  wr_en    = 1'b1;
                  wr_addr  = '0;
                  len_in   = LW'(1);
                  phase_in = PH_URL;
               end
            end
            PH_URL: begin
               if (payload_byte == hprld_pkg::ASCII_SPACE) begin
                  vcand_in = 2'b11;
                  vidx_in  = 3'd0;
                  phase_in = PH_VERSION;
               end else if (len_ff < URL_LIMIT) begin
                  wr_en  = 1'b1;
                  len_in = len_ff + LW'(1);
               end
            end
            PH_VERSION: begin
               vcand_in = vcand_next;
               if (vcand_next == 2'b00) begin
                  phase_in = PH_IDLE;
               end else if (vidx_ff == hprld_pkg::VERSION_LAST) begin
                  launch.valid = detect_enable;
                  phase_in     = PH_IDLE;
               end else begin
                  vidx_in = vidx_ff + 3'd1;
               end
            end
            PH_IDLE: begin
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (in_accept && segment_end)) begin
         phase_ff  <= PH_METHOD;
         pos_ff    <= 3'd0;
         cand_ff   <= 5'b11111;
         method_ff <= 3'd0;
         len_ff    <= '0;
         vcand_ff  <= 2'b11;
         vidx_ff   <= 3'd0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         cand_ff   <= cand_in;
         method_ff <= method_in;
         len_ff    <= len_in;
         vcand_ff  <= vcand_in;
         vidx_ff   <= vidx_in;
      end
   end

endmodule

@@ design/hprld_emitter.sv @@
module hprld_emitter #(
   parameter int AW = 6,
   parameter int LW = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hprld_pkg::launch_type launch,
   input  logic [LW-1:0]         launch_len,
   output logic                  rd_en,
   output logic [AW-1:0]         rd_addr,
   input  logic [7:0]            rd_data,
   output logic                  busy,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_url_char,
   output logic                  rsp_url_end,
   output logic [2:0]            rsp_method_code,
   output logic                  rsp_version_code
);

   logic          busy_ff, busy_in;
   logic [LW-1:0] len_ff, len_in;
   logic [2:0]    method_ff, method_in;
   logic          version_ff, version_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic          pend_ff, pend_in;
   logic          pend_end_ff, pend_end_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_char_ff, out_char_in;
   logic          out_end_ff, out_end_in;

   logic          take;
   logic          issue;

   assign take  = out_valid_ff && !rsp_stall;
   // A read is issued only when the output register is sure to be free as the
   // data returns in the cycle after the read, so no skid entry is needed.
   assign issue = busy_ff && (idx_ff < len_ff) && !pend_ff && (!out_valid_ff || !rsp_stall);

   assign rd_en   = issue;
   assign rd_addr = idx_ff[AW-1:0];

   always_comb begin
      busy_in      = busy_ff;
      len_in       = len_ff;
      method_in    = method_ff;
      version_in   = version_ff;
      idx_in       = idx_ff;
      pend_in      = issue;
      pend_end_in  = (idx_ff + LW'(1)) == len_ff;
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_end_in   = out_end_ff;

      if (launch.valid) begin
         busy_in    = 1'b1;
         len_in     = launch_len;
         method_in  = launch.method;
         version_in = launch.version;
         idx_in     = '0;
      end else if (issue) begin
         idx_in = idx_ff + LW'(1);
      end

      if (pend_ff) begin
         out_valid_in = 1'b1;
         out_char_in  = rd_data;
         out_end_in   = pend_end_ff;
      end else if (take) begin
         out_valid_in = 1'b0;
      end

      if (take && out_end_ff) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      len_ff      <= len_in;
      method_ff   <= method_in;
      version_ff  <= version_in;
      idx_ff      <= idx_in;
      pend_end_ff <= pend_end_in;
      out_char_ff <= out_char_in;
      out_end_ff  <= out_end_in;
   end

   assign busy             = busy_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_url_char     = out_char_ff;
   assign rsp_url_end      = out_end_ff;
   assign rsp_method_code  = method_ff;
   assign rsp_version_code = version_ff;

endmodule

@@ design/http_proxy_request_line_detector_unit.sv @@
// Input bytes are taken one per cycle while no URL is being sent out.
// The accepted item with the eighth version byte starts a URL run when detection
// is enabled; each URL byte goes through one URL memory read, then the output
// register, before it shows on rsp, and rsp_stall can hold it there.
// req_stall stays high for the whole run.
// Reset is synchronous and clears control state; the URL memory is not cleared.
module http_proxy_request_line_detector_unit #(
   parameter int URL_MAX = hprld_pkg::URL_MAX_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_payload_byte,
   input  logic       req_segment_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_url_char,
   output logic       rsp_url_end,
   output logic [2:0] rsp_method_code,
   output logic       rsp_version_code,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_detect_enable
);

   localparam int DEPTH = URL_MAX - 1;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW    = $clog2(URL_MAX);

   logic                  detect_enable_ff;
   logic                  in_accept;
   logic                  emit_busy;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [7:0]            wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [7:0]            rd_data;
   hprld_pkg::launch_type launch;
   logic [LW-1:0]         launch_len;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         detect_enable_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         detect_enable_ff <= csr_detect_enable;
      end
   end

   // Input stalls during a URL run, so memory writes and reads never overlap.
   assign req_stall = emit_busy;
   assign in_accept = req_valid && !req_stall;

   hprld_parser #(
      .URL_MAX (URL_MAX),
      .AW      (AW),
      .LW      (LW)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .in_accept     (in_accept),
      .payload_byte  (req_payload_byte),
      .segment_end   (req_segment_end),
      .detect_enable (detect_enable_ff),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .launch        (launch),
      .launch_len    (launch_len)
   );

   hprld_url_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_url_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   hprld_emitter #(
      .AW (AW),
      .LW (LW)
   ) u_emitter (
      .clock            (clock),
      .reset            (reset),
      .launch           (launch),
      .launch_len       (launch_len),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .busy             (emit_busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_url_char     (rsp_url_char),
      .rsp_url_end      (rsp_url_end),
      .rsp_method_code  (rsp_method_code),
      .rsp_version_code (rsp_version_code)
   );

endmodule

@@ design/hprld_checker.sv @@
module hprld_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_url_char,
   input logic       rsp_url_end,
   input logic [2:0] rsp_method_code,
   input logic       rsp_version_code
);

   // A held result item keeps its payload.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_url_char) && $stable(rsp_url_end))
      else $error("stalled result item changed");

   // No input item is taken while a URL run is on the output.
   a_no_accept_in_run : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted during URL run");

   // The last URL byte closes the run.
   a_run_ends : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_url_end |=> !rsp_valid && !req_stall)
      else $error("result after final URL byte");

   // Method and version fields stay fixed through one URL run.
   a_run_fields : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_url_end |=> ##1 !rsp_valid
         || (rsp_method_code == $past(rsp_method_code, 2)
            && rsp_version_code == $past(rsp_version_code, 2)))
      else $error("method or version changed within a URL run");

   // Reset leaves no result pending.
   a_reset_clear : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind http_proxy_request_line_detector_unit hprld_checker u_hprld_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_url_char      (rsp_url_char),
   .rsp_url_end       (rsp_url_end),
   .rsp_method_code   (rsp_method_code),
   .rsp_version_code  (rsp_version_code)
);
